FILE: src/mhtq_pkg.sv
// Shared types and codes for the min-heap timer queue.
// Used by the controller, the datapath and the top level; no dependencies.
package mhtq_pkg;

  // operation codes on the input tuser
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_ADJ  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // result kinds on the output tuser
  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // acknowledge status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam int unsigned OutIdW   = 16;
  localparam logic [31:0] EmptyDly = 32'hFFFF_FFFF;
  localparam logic [31:0] DelayMax = 32'h7FFF_FFFF;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD_INIT,
    CMD_RD_IDX,
    CMD_SRCH_NEXT,
    CMD_DEL_FOUND,
    CMD_ADJ_FOUND,
    CMD_RD_LAST,
    CMD_MOV_LOAD,
    CMD_RD_PARENT,
    CMD_UP_MOVE,
    CMD_WR_MOV,
    CMD_RD_C1,
    CMD_C1_CAP,
    CMD_C2_CMP,
    CMD_DOWN_MOVE,
    CMD_RELOAD,
    CMD_RD_ROOT,
    CMD_EMIT_POP,
    CMD_EMIT_ACK,
    CMD_EMIT_RPT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       count_zero;
    logic       idx_end;
    logic       id_match;
    logic       del_last;
    logic       pos_zero;
    logic       no_child;
    logic       up_swap;
    logic       down_stop;
    logic       due;
    logic       out_free;
  } stat_t;

endpackage

FILE: src/min_heap_timer_queue_unit.sv
// Top level of the min-heap timer queue.
// Depends on mhtq_pkg, mhtq_ctrl, mhtq_dp and mhtq_ram.
//
// Input stream: tuser carries the operation (add, delete, adjust, tick),
// tdata the timer id, expiry time, delay and current time. Output stream:
// tuser carries the result kind, tlast marks the final item of an input.
// Add, delete and adjust each give one acknowledge with a status; a tick
// gives one item per expired timer and then a next-delay report.
// One item is worked at a time; tready is high only while idle. An item's
// work grows with its search steps (at most one per entry) and with the
// levels it sifts down and up; a tick adds one sift-down per expired timer.
// The heap RAM has one write port and one registered read port, so one
// entry is read per cycle.
// The output register lets the next item be taken while the last result
// still waits; a stalled receiver holds the block at its next result.
// Reset empties the heap at once (no clearing pass); tvalid drops.
module min_heap_timer_queue_unit
  import mhtq_pkg::*;
#(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // timer_id[15:0], expire_at[47:16], delay_ms[78:48], now_time[110:79], zero pad
  input  logic [111:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // expired_id[15:0], next_delay[47:16], status[49:48], zero pad
  output logic [55:0]  m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  cmd_t        cmd;
  stat_t       stat;
  logic [15:0] out_id;
  logic [31:0] out_delay;
  logic [1:0]  out_status;

  mhtq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mhtq_dp #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_op_i     (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[15:0]),
    .in_at_i     (s_axis_tdata_i[47:16]),
    .in_dly_i    (s_axis_tdata_i[78:48]),
    .in_now_i    (s_axis_tdata_i[110:79]),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_id_o    (out_id),
    .out_delay_o (out_delay),
    .out_status_o(out_status),
    .out_last_o  (m_axis_tlast_o)
  );

  // pack the result fields
  assign m_axis_tdata_o = {6'b0, out_status, out_delay, out_id};

endmodule

FILE: src/mhtq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/mhtq_ctrl.sv
// Sequencing state machine for the min-heap timer queue.
// Depends on mhtq_pkg; drives commands into mhtq_dp and reads its status.
module mhtq_ctrl
  import mhtq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_ACK     = 5'd2;
  localparam logic [4:0] S_SRCH    = 5'd3;
  localparam logic [4:0] S_SCMP    = 5'd4;
  localparam logic [4:0] S_DELCHK  = 5'd5;
  localparam logic [4:0] S_MOVLD   = 5'd6;
  localparam logic [4:0] S_DNCHK   = 5'd7;
  localparam logic [4:0] S_DNC1    = 5'd8;
  localparam logic [4:0] S_DNC2    = 5'd9;
  localparam logic [4:0] S_DNDEC   = 5'd10;
  localparam logic [4:0] S_AFTDN   = 5'd11;
  localparam logic [4:0] S_RELOAD  = 5'd12;
  localparam logic [4:0] S_RLLD    = 5'd13;
  localparam logic [4:0] S_UPCHK   = 5'd14;
  localparam logic [4:0] S_UPCMP   = 5'd15;
  localparam logic [4:0] S_TKCHK   = 5'd16;
  localparam logic [4:0] S_TKCMP   = 5'd17;
  localparam logic [4:0] S_TKEMIT  = 5'd18;
  localparam logic [4:0] S_TKNEXT  = 5'd19;
  localparam logic [4:0] S_RPT     = 5'd20;

  logic [4:0] state_q, state_d;
  logic [1:0] ack_st_q, ack_st_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ack_st_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      ack_st_q <= ack_st_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command
  always_comb begin
    state_d       = state_q;
    ack_st_d      = ack_st_q;
    cmd_o.op      = CMD_NONE;
    cmd_o.status  = ack_st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_ADD: begin
            if (stat_i.full) begin
              ack_st_d = ST_FULL;
              state_d  = S_ACK;
            end else begin
              cmd_o.op = CMD_ADD_INIT;
              state_d  = S_UPCHK;
            end
          end
          OP_DEL, OP_ADJ: state_d = S_SRCH;
          default: state_d = S_TKCHK;
        endcase
      end
      S_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_EMIT_ACK;
          state_d  = S_IDLE;
        end
      end
      S_SRCH: begin
        if (stat_i.idx_end) begin
          ack_st_d = ST_NOT_FOUND;
          state_d  = S_ACK;
        end else begin
          cmd_o.op = CMD_RD_IDX;
          state_d  = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!stat_i.id_match) begin
          cmd_o.op = CMD_SRCH_NEXT;
          state_d  = S_SRCH;
        end else if (stat_i.op == OP_DEL) begin
          cmd_o.op = CMD_DEL_FOUND;
          state_d  = S_DELCHK;
        end else begin
          cmd_o.op = CMD_ADJ_FOUND;
          state_d  = S_DNCHK;
        end
      end
      S_DELCHK: begin
        if (stat_i.del_last) begin
          ack_st_d = ST_DONE;
          state_d  = S_ACK;
        end else begin
          cmd_o.op = CMD_RD_LAST;
          state_d  = S_MOVLD;
        end
      end
      S_MOVLD: begin
        cmd_o.op = CMD_MOV_LOAD;
        state_d  = S_DNCHK;
      end
      S_DNCHK: begin
        if (stat_i.no_child) begin
          cmd_o.op = CMD_WR_MOV;
          state_d  = S_AFTDN;
        end else begin
          cmd_o.op = CMD_RD_C1;
          state_d  = S_DNC1;
        end
      end
      S_DNC1: begin
        cmd_o.op = CMD_C1_CAP;
        state_d  = S_DNC2;
      end
      S_DNC2: begin
        cmd_o.op = CMD_C2_CMP;
        state_d  = S_DNDEC;
      end
      S_DNDEC: begin
        if (stat_i.down_stop) begin
          cmd_o.op = CMD_WR_MOV;
          state_d  = S_AFTDN;
        end else begin
          cmd_o.op = CMD_DOWN_MOVE;
          state_d  = S_DNCHK;
        end
      end
      S_AFTDN: begin
        state_d = (stat_i.op == OP_TICK) ? S_TKCHK : S_RELOAD;
      end
      S_RELOAD: begin
        cmd_o.op = CMD_RELOAD;
        state_d  = S_RLLD;
      end
      S_RLLD: begin
        cmd_o.op = CMD_MOV_LOAD;
        state_d  = S_UPCHK;
      end
      S_UPCHK: begin
        if (stat_i.pos_zero) begin
          cmd_o.op = CMD_WR_MOV;
          ack_st_d = ST_DONE;
          state_d  = S_ACK;
        end else begin
          cmd_o.op = CMD_RD_PARENT;
          state_d  = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (stat_i.up_swap) begin
          cmd_o.op = CMD_UP_MOVE;
          state_d  = S_UPCHK;
        end else begin
          cmd_o.op = CMD_WR_MOV;
          ack_st_d = ST_DONE;
          state_d  = S_ACK;
        end
      end
      S_TKCHK: begin
        if (stat_i.count_zero) begin
          state_d = S_RPT;
        end else begin
          cmd_o.op = CMD_RD_ROOT;
          state_d  = S_TKCMP;
        end
      end
      S_TKCMP: begin
        state_d = stat_i.due ? S_TKEMIT : S_RPT;
      end
      S_TKEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_EMIT_POP;
          state_d  = S_TKNEXT;
        end
      end
      S_TKNEXT: begin
        if (stat_i.count_zero) begin
          state_d = S_RPT;
        end else begin
          cmd_o.op = CMD_RD_LAST;
          state_d  = S_MOVLD;
        end
      end
      S_RPT: begin
        if (stat_i.out_free) begin
          cmd_o.op = CMD_EMIT_RPT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/mhtq_dp.sv
// Datapath of the min-heap timer queue: heap RAM, index and entry registers,
// output register. Depends on mhtq_pkg and mhtq_ram; driven by mhtq_ctrl.
module mhtq_dp
  import mhtq_pkg::*;
#(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [1:0]  in_op_i,
  input  logic [15:0] in_id_i,
  input  logic [31:0] in_at_i,
  input  logic [30:0] in_dly_i,
  input  logic [31:0] in_now_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [15:0] out_id_o,
  output logic [31:0] out_delay_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = ID_BITS + TIME_BITS;

  // true when a is strictly earlier than b, wrapping
  function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return d[TIME_BITS-1];
  endfunction

  logic [1:0]           op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] at_q, now_q, dly_q;
  logic [CW-1:0]        count_q, idx_q;
  logic [AW-1:0]        pos_q, orig_q, cidx_q;
  logic [ID_BITS-1:0]   mov_id_q, ch_id_q;
  logic [TIME_BITS-1:0] mov_exp_q, ch_exp_q;

  logic                 out_valid_q, out_last_q;
  logic [1:0]           out_kind_q, out_status_q;
  logic [15:0]          out_id_q;
  logic [31:0]          out_delay_q;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [TIME_BITS-1:0] rd_exp, now_diff;
  logic [AW+1:0]        c1w, c2w, cnt_w;
  logic [AW-1:0]        parent;
  logic [63:0]          diff_wide;
  logic [31:0]          rpt_delay;
  logic                 out_free;

  assign rd_id     = rdata[EW-1:TIME_BITS];
  assign rd_exp    = rdata[TIME_BITS-1:0];
  assign c1w       = {1'b0, pos_q, 1'b1};
  assign c2w       = c1w + 1'b1;
  assign cnt_w     = (AW + 2)'(count_q);
  assign parent    = (pos_q - 1'b1) >> 1;
  assign now_diff  = rd_exp - now_q;
  assign diff_wide = 64'(now_diff);
  assign out_free  = !out_valid_q || out_ready_i;

  // clamp the root's distance from now for the report; an empty heap reports EmptyDly
  always_comb begin
    if (count_q == '0) begin
      rpt_delay = EmptyDly;
    end else if (now_diff[TIME_BITS-1]) begin
      rpt_delay = '0;
    end else if (diff_wide > 64'(DelayMax)) begin
      rpt_delay = DelayMax;
    end else begin
      rpt_delay = diff_wide[31:0];
    end
  end

  // RAM port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {mov_id_q, mov_exp_q};
    ram_re    = 1'b0;
    ram_raddr = pos_q;
    case (cmd_i.op)
      CMD_WR_MOV: ram_we = 1'b1;
      CMD_UP_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = rdata;
      end
      CMD_DOWN_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = {ch_id_q, ch_exp_q};
      end
      CMD_RD_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q[AW-1:0];
      end
      CMD_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = count_q[AW-1:0];
      end
      CMD_RD_PARENT: begin
        ram_re    = 1'b1;
        ram_raddr = parent;
      end
      CMD_RD_C1: begin
        ram_re    = 1'b1;
        ram_raddr = c1w[AW-1:0];
      end
      CMD_C1_CAP: begin
        ram_re    = 1'b1;
        ram_raddr = c2w[AW-1:0];
      end
      CMD_RELOAD: begin
        ram_re    = 1'b1;
        ram_raddr = orig_q;
      end
      CMD_RD_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      default: ;
    endcase
  end

  mhtq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  // control registers: count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == CMD_ADD_INIT) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.op == CMD_DEL_FOUND || cmd_i.op == CMD_EMIT_POP) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.op == CMD_EMIT_POP || cmd_i.op == CMD_EMIT_ACK ||
          cmd_i.op == CMD_EMIT_RPT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        op_q  <= in_op_i;
        id_q  <= ID_BITS'(in_id_i);
        at_q  <= TIME_BITS'(in_at_i);
        now_q <= TIME_BITS'(in_now_i);
        dly_q <= TIME_BITS'(in_dly_i);
        idx_q <= '0;
      end
      CMD_ADD_INIT: begin
        pos_q     <= count_q[AW-1:0];
        orig_q    <= count_q[AW-1:0];
        mov_id_q  <= id_q;
        mov_exp_q <= at_q;
      end
      CMD_SRCH_NEXT: idx_q <= idx_q + 1'b1;
      CMD_DEL_FOUND: begin
        pos_q  <= idx_q[AW-1:0];
        orig_q <= idx_q[AW-1:0];
      end
      CMD_ADJ_FOUND: begin
        pos_q     <= idx_q[AW-1:0];
        orig_q    <= idx_q[AW-1:0];
        mov_id_q  <= id_q;
        mov_exp_q <= now_q + dly_q;
      end
      CMD_MOV_LOAD: begin
        mov_id_q  <= rd_id;
        mov_exp_q <= rd_exp;
      end
      CMD_UP_MOVE: pos_q <= parent;
      CMD_C1_CAP: begin
        ch_id_q  <= rd_id;
        ch_exp_q <= rd_exp;
        cidx_q   <= c1w[AW-1:0];
      end
      CMD_C2_CMP: begin
        if (c2w < cnt_w && earlier(rd_exp, ch_exp_q)) begin
          ch_id_q  <= rd_id;
          ch_exp_q <= rd_exp;
          cidx_q   <= c2w[AW-1:0];
        end
      end
      CMD_DOWN_MOVE: pos_q <= cidx_q;
      CMD_RELOAD: pos_q <= orig_q;
      CMD_EMIT_POP: begin
        pos_q        <= '0;
        orig_q       <= '0;
        out_kind_q   <= KIND_EXPIRED;
        out_id_q     <= OutIdW'(rd_id);
        out_delay_q  <= '0;
        out_status_q <= ST_DONE;
        out_last_q   <= 1'b0;
      end
      CMD_EMIT_ACK: begin
        out_kind_q   <= KIND_ACK;
        out_id_q     <= '0;
        out_delay_q  <= '0;
        out_status_q <= cmd_i.status;
        out_last_q   <= 1'b1;
      end
      CMD_EMIT_RPT: begin
        out_kind_q   <= KIND_REPORT;
        out_id_q     <= '0;
        out_delay_q  <= rpt_delay;
        out_status_q <= ST_DONE;
        out_last_q   <= 1'b1;
      end
      default: ;
    endcase
  end

  // status toward the controller
  assign stat_o.op         = op_q;
  assign stat_o.full       = (count_q == CW'(DEPTH));
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.idx_end    = (idx_q >= count_q);
  assign stat_o.id_match   = (rd_id == id_q);
  assign stat_o.del_last   = (CW'(orig_q) == count_q);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.no_child   = (c1w >= cnt_w);
  assign stat_o.up_swap    = earlier(mov_exp_q, rd_exp);
  assign stat_o.down_stop  = earlier(mov_exp_q, ch_exp_q);
  assign stat_o.due        = now_diff[TIME_BITS-1] || (now_diff == '0);
  assign stat_o.out_free   = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_id_o     = out_id_q;
  assign out_delay_o  = out_delay_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_EMIT_POP || cmd_i.op == CMD_EMIT_ACK ||
     cmd_i.op == CMD_EMIT_RPT) |-> out_free)
    else $error("result loaded over a pending item");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_EMIT_POP |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not shrink the heap");

  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_ADD_INIT |-> count_q < CW'(DEPTH))
    else $error("add into a full heap");
`endif

endmodule
